// ===== rtl/lps_pkg.sv =====
package lps_pkg;

  localparam int SLOTS         = 8;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int COUNT_BITS    = $clog2(SLOTS + 1);
  localparam int MAX_STEPS     = 8;
  localparam int STEP_BITS     = $clog2(MAX_STEPS);
  localparam int BUILTIN_SLOTS = 4;
  localparam int PERIOD_BITS   = 16;
  localparam int LEN_BITS      = 4;
  localparam int COLOR_BITS    = 16;
  localparam int MODE_NUM_BITS = 4;
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_BUTTON      = 2'd1,
    ACT_SET_MODE    = 2'd2,
    ACT_NEW_PATTERN = 2'd3
  } action_t;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic [LEN_BITS-1:0]    length;
    logic [COLOR_BITS-1:0]  colors;
    logic [STEP_BITS-1:0]   step;
    logic [PERIOD_BITS-1:0] subcount;
  } slot_entry_t;

  typedef struct packed {
    logic        en;
    slot_idx_t   addr;
    slot_entry_t data;
  } slot_wr_t;

  typedef struct packed {
    logic [1:0]             led_color;
    logic [2:0]             active_mode;
    logic [PERIOD_BITS-1:0] echo_period;
    logic [LEN_BITS-1:0]    echo_length;
    logic                   status;
  } result_t;

  function automatic logic [1:0] color_of(logic [COLOR_BITS-1:0] colors,
                                          logic [STEP_BITS-1:0] step);
    return colors[{step, 1'b0} +: 2];
  endfunction

  // built-in patterns for the low slots, all else zero
  function automatic slot_entry_t slot_reset_value(slot_idx_t idx);
    slot_entry_t e;
    e = '0;
    if (32'(idx) < BUILTIN_SLOTS) begin
      case (idx)
        SLOT_BITS'(0): begin
          e.period = PERIOD_BITS'(500);
          e.length = LEN_BITS'(4);
          e.colors = COLOR_BITS'(16'h00D9);
        end
        SLOT_BITS'(1): begin
          e.period = PERIOD_BITS'(200);
          e.length = LEN_BITS'(3);
          e.colors = COLOR_BITS'(16'h002D);
        end
        SLOT_BITS'(2): begin
          e.period = PERIOD_BITS'(5000);
          e.length = LEN_BITS'(2);
          e.colors = COLOR_BITS'(16'h0009);
        end
        SLOT_BITS'(3): begin
          e.period = PERIOD_BITS'(75);
          e.length = LEN_BITS'(6);
          e.colors = COLOR_BITS'(16'h09B7);
        end
        default: e = '0;
      endcase
    end
    return e;
  endfunction

endpackage

// ===== rtl/lps_if.sv =====
interface lps_in_if import lps_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic                     button_level;
  logic [MODE_NUM_BITS-1:0] mode_number;
  logic [PERIOD_BITS-1:0]   new_period;
  logic [LEN_BITS-1:0]      new_length;
  logic [COLOR_BITS-1:0]    new_colors;

  modport source (output valid, action, button_level, mode_number, new_period,
                  new_length, new_colors, input ready);
  modport sink (input valid, action, button_level, mode_number, new_period,
                new_length, new_colors, output ready);
endinterface

interface lps_out_if import lps_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [1:0]             led_color;
  logic [2:0]             active_mode;
  logic [PERIOD_BITS-1:0] echo_period;
  logic [LEN_BITS-1:0]    echo_length;
  logic                   status;

  modport source (output valid, led_color, active_mode, echo_period, echo_length,
                  status, input ready);
  modport sink (input valid, led_color, active_mode, echo_period, echo_length,
                status, output ready);
endinterface

// ===== rtl/lps_slot_store.sv =====
module lps_slot_store import lps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  slot_idx_t   rd_addr,
  input  slot_wr_t    wr,
  output slot_entry_t rd_data
);

  slot_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] written;
  slot_entry_t      mem_q;
  logic             written_q;
  slot_idx_t        addr_q;
  logic             last_en;
  slot_idx_t        last_addr;
  slot_entry_t      last_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q     <= mem[rd_addr];
    written_q <= written[rd_addr];
    addr_q    <= rd_addr;
    last_addr <= wr.addr;
    last_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      last_en <= 1'b0;
    end else begin
      last_en <= wr.en;
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
    end
  end

  // write in the read cycle wins, unwritten slots show their reset pattern
  always_comb begin
    if (last_en && last_addr == addr_q) begin
      rd_data = last_data;
    end else if (written_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = slot_reset_value(addr_q);
    end
  end

endmodule

// ===== rtl/lps_out_fifo.sv =====
module lps_out_fifo import lps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  result_t                 push_data,
  output logic [OUT_CNT_BITS-1:0] level,
  lps_out_if.source               res
);

  result_t                 buffer [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] head;
  logic [OUT_PTR_BITS-1:0] tail;
  logic                    pop;
  result_t                 front;

  assign pop   = res.valid && res.ready;
  assign front = buffer[head];

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + OUT_PTR_BITS'(1);
      end
      if (pop) begin
        head <= head + OUT_PTR_BITS'(1);
      end
      level <= level + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
    end
  end

  assign res.valid       = (level != '0);
  assign res.led_color   = front.led_color;
  assign res.active_mode = front.active_mode;
  assign res.echo_period = front.echo_period;
  assign res.echo_length = front.echo_length;
  assign res.status      = front.status;

endmodule

// ===== rtl/led_pattern_sequencer.sv =====
// LED pattern sequencer with eight pattern slots.
// items: one request per handshake (valid and ready high at a clock edge):
//   a millisecond tick, a button sample, a set-mode request or a new pattern.
// results: exactly one result per request, in request order: the colour now
//   shown, the slot now playing, the echo of an accepted pattern and a
//   reject flag.
// A taken request is registered in a second stage, whose result is pushed into
//   the result queue that offers it on the results side.
// Throughput: one request per cycle while items.ready is high; slot state
//   lives in one synchronous memory read in the cycle of acceptance and
//   written back in the next cycle, with the write forwarded to the following read.
// A four-entry result queue decouples the sides: when the receiver stalls the
//   queue fills and items.ready drops while requests in flight still fit.
// Reset: synchronous, active high; slots 0 to 3 hold the built-in patterns,
//   all positions are zero, mode 0 plays, four modes are defined. No clearing
//   pass is needed, requests are taken as soon as reset is released.
module led_pattern_sequencer import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lps_in_if.sink    items,
  lps_out_if.source results
);

  slot_idx_t                play_slot;
  logic [COUNT_BITS-1:0]    mode_count;
  slot_idx_t                next_free_slot;
  logic                     button_held;

  slot_idx_t                mode_next;
  logic [COUNT_BITS-1:0]    count_next;
  slot_idx_t                free_next;
  logic                     held_next;
  logic                     a_status;
  logic                     a_new_ok;
  logic                     accept;
  action_t                  act;

  logic                     b_valid;
  logic                     b_tick;
  logic                     b_new;
  slot_idx_t                b_slot;
  slot_idx_t                b_mode;
  logic                     b_status;
  logic [PERIOD_BITS-1:0]   b_period;
  logic [LEN_BITS-1:0]      b_length;
  logic [COLOR_BITS-1:0]    b_colors;

  slot_entry_t              cur;
  slot_entry_t              ticked;
  slot_wr_t                 wr;
  logic [PERIOD_BITS-1:0]   sub_inc;
  logic [LEN_BITS-1:0]      step_inc;
  logic [1:0]               color;
  result_t                  res_data;
  logic [OUT_CNT_BITS-1:0]  level;

  assign act    = action_t'(items.action);
  assign accept = items.valid && items.ready;
  assign items.ready = (level + OUT_CNT_BITS'(b_valid)) < OUT_CNT_BITS'(OUT_DEPTH);

  always_comb begin
    mode_next  = play_slot;
    count_next = mode_count;
    free_next  = next_free_slot;
    held_next  = button_held;
    a_status   = 1'b0;
    a_new_ok   = 1'b0;
    case (act)
      ACT_TICK: begin
      end
      ACT_BUTTON: begin
        if (items.button_level && !button_held) begin
          if (COUNT_BITS'(play_slot) + COUNT_BITS'(1) >= mode_count) begin
            mode_next = '0;
          end else begin
            mode_next = play_slot + SLOT_BITS'(1);
          end
          held_next = 1'b1;
        end else if (!items.button_level && button_held) begin
          held_next = 1'b0;
        end
      end
      ACT_SET_MODE: begin
        if (items.mode_number != '0 && 32'(items.mode_number) <= 32'(mode_count)) begin
          mode_next = SLOT_BITS'(items.mode_number - MODE_NUM_BITS'(1));
        end else begin
          a_status = 1'b1;
        end
      end
      ACT_NEW_PATTERN: begin
        if (items.new_period == '0 || items.new_length == '0 ||
            32'(items.new_length) > MAX_STEPS) begin
          a_status = 1'b1;
        end else begin
          a_new_ok = 1'b1;
          if (next_free_slot == SLOT_BITS'(SLOTS - 1)) begin
            free_next = SLOT_BITS'(BUILTIN_SLOTS);
          end else begin
            free_next = next_free_slot + SLOT_BITS'(1);
          end
          if (mode_count < COUNT_BITS'(SLOTS)) begin
            count_next = mode_count + COUNT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_slot      <= '0;
      mode_count     <= COUNT_BITS'(BUILTIN_SLOTS);
      next_free_slot <= SLOT_BITS'(BUILTIN_SLOTS);
      button_held    <= 1'b0;
      b_valid        <= 1'b0;
    end else begin
      b_valid <= accept;
      if (accept) begin
        play_slot      <= mode_next;
        mode_count     <= count_next;
        next_free_slot <= free_next;
        button_held    <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_tick   <= (act == ACT_TICK);
      b_new    <= a_new_ok;
      b_slot   <= next_free_slot;
      b_mode   <= mode_next;
      b_status <= a_status;
      b_period <= items.new_period;
      b_length <= items.new_length;
      b_colors <= items.new_colors;
    end
  end

  lps_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (mode_next),
    .wr      (wr),
    .rd_data (cur)
  );

  // tick update of the playing slot
  always_comb begin
    sub_inc  = cur.subcount + PERIOD_BITS'(1);
    step_inc = LEN_BITS'(cur.step) + LEN_BITS'(1);
    ticked   = cur;
    if (sub_inc >= cur.period || cur.period == '0) begin
      ticked.subcount = '0;
      if (step_inc >= cur.length) begin
        ticked.step = '0;
      end else begin
        ticked.step = step_inc[STEP_BITS-1:0];
      end
    end else begin
      ticked.subcount = sub_inc;
    end
  end

  always_comb begin
    wr.en   = b_valid && (b_tick || b_new);
    wr.addr = b_new ? b_slot : b_mode;
    if (b_new) begin
      wr.data.period   = b_period;
      wr.data.length   = b_length;
      wr.data.colors   = b_colors;
      wr.data.step     = '0;
      wr.data.subcount = '0;
    end else begin
      wr.data = ticked;
    end
  end

  always_comb begin
    if (b_tick) begin
      color = color_of(ticked.colors, ticked.step);
    end else if (b_new && b_slot == b_mode) begin
      color = b_colors[1:0];
    end else begin
      color = color_of(cur.colors, cur.step);
    end
    res_data.led_color   = color;
    res_data.active_mode = 3'(b_mode);
    res_data.echo_period = b_new ? b_period : '0;
    res_data.echo_length = b_new ? b_length : '0;
    res_data.status      = b_status;
  end

  lps_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (b_valid),
    .push_data (res_data),
    .level     (level),
    .res       (results)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (32'(level) + 32'(b_valid)) <= OUT_DEPTH)
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    mode_count >= COUNT_BITS'(BUILTIN_SLOTS) && mode_count <= COUNT_BITS'(SLOTS))
    else $error("mode count out of range");

  a_mode_defined: assert property (@(posedge clk) disable iff (rst)
    COUNT_BITS'(play_slot) < mode_count)
    else $error("playing an undefined slot");

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    32'(next_free_slot) >= BUILTIN_SLOTS)
    else $error("ring pointer in built-in slots");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> !(b_tick && b_new))
    else $error("tick and new pattern in one request");
`endif

endmodule

// ===== sim/tb.sv =====
module tb import lps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT       = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_AT       = 600;
  localparam int CALM_FROM      = 700;
  localparam int CALM_TO        = 900;
  localparam int RANDOM_ITEMS   = 1150;

  typedef struct packed {
    action_t                  action;
    logic                     button_level;
    logic [MODE_NUM_BITS-1:0] mode_number;
    logic [PERIOD_BITS-1:0]   new_period;
    logic [LEN_BITS-1:0]      new_length;
    logic [COLOR_BITS-1:0]    new_colors;
    logic                     drain;
  } request_t;

  logic clk;
  logic rst;

  lps_in_if  requests ();
  lps_out_if results ();

  led_pattern_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .items   (requests),
    .results (results)
  );

  // pattern table as the block should hold it
  logic [PERIOD_BITS-1:0] pat_period [SLOTS];
  logic [LEN_BITS-1:0]    pat_len    [SLOTS];
  logic [COLOR_BITS-1:0]  pat_colors [SLOTS];
  logic [STEP_BITS-1:0]   pat_step   [SLOTS];
  logic [PERIOD_BITS-1:0] pat_sub    [SLOTS];
  logic [SLOT_BITS-1:0]   play_mode;
  logic [COUNT_BITS-1:0]  defined_modes;
  logic [SLOT_BITS-1:0]   ring_slot;
  logic                   btn_held;

  request_t pending [$];
  result_t  display_q [$];
  request_t cur_req;

  bit offer_taken;
  int reqs_taken;
  int results_seen;
  int mismatches;
  int stuck_cycles;
  int hold_left;
  bit hold_done;
  logic calm;

  assign calm = reqs_taken >= CALM_FROM && reqs_taken < CALM_TO;

  always #5ns clk = ~clk;

  function automatic request_t make_request(action_t a, logic lvl,
                                            logic [MODE_NUM_BITS-1:0] mn,
                                            logic [PERIOD_BITS-1:0] per,
                                            logic [LEN_BITS-1:0] len,
                                            logic [COLOR_BITS-1:0] col);
    request_t r;
    r.action       = a;
    r.button_level = lvl;
    r.mode_number  = mn;
    r.new_period   = per;
    r.new_length   = len;
    r.new_colors   = col;
    r.drain        = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // apply one request to the pattern table and queue the display it leads to
  task automatic play_request(input request_t r);
    result_t d;
    int m;
    int s;
    logic [PERIOD_BITS-1:0] nxt;
    d = '0;
    m = int'(play_mode);
    case (r.action)
      ACT_TICK: begin
        nxt = pat_sub[m] + 1'b1;
        if (nxt >= pat_period[m] || pat_period[m] == '0) begin
          pat_sub[m] = '0;
          if (int'(pat_step[m]) + 1 >= int'(pat_len[m])) pat_step[m] = '0;
          else pat_step[m] = pat_step[m] + 1'b1;
        end else begin
          pat_sub[m] = nxt;
        end
      end
      ACT_BUTTON: begin
        if (r.button_level && !btn_held) begin
          if (int'(play_mode) + 1 >= int'(defined_modes)) play_mode = '0;
          else play_mode = play_mode + 1'b1;
          btn_held = 1'b1;
        end else if (!r.button_level && btn_held) begin
          btn_held = 1'b0;
        end
      end
      ACT_SET_MODE: begin
        if (r.mode_number != '0 && int'(r.mode_number) <= int'(defined_modes))
          play_mode = SLOT_BITS'(int'(r.mode_number) - 1);
        else
          d.status = 1'b1;
      end
      ACT_NEW_PATTERN: begin
        if (r.new_period == '0 || r.new_length == '0 || int'(r.new_length) > MAX_STEPS) begin
          d.status = 1'b1;
        end else begin
          s = int'(ring_slot);
          pat_period[s] = r.new_period;
          pat_len[s]    = r.new_length;
          pat_colors[s] = r.new_colors;
          pat_step[s]   = '0;
          pat_sub[s]    = '0;
          d.echo_period = r.new_period;
          d.echo_length = r.new_length;
          ring_slot = (s >= SLOTS - 1) ? SLOT_BITS'(BUILTIN_SLOTS) : SLOT_BITS'(s + 1);
          if (int'(defined_modes) < SLOTS) defined_modes = defined_modes + 1'b1;
        end
      end
      default: ;
    endcase
    m = int'(play_mode);
    d.led_color   = pat_colors[m][2*int'(pat_step[m]) +: 2];
    d.active_mode = 3'(play_mode);
    display_q.push_back(d);
  endtask

  // request side
  always @(negedge clk) begin
    if (!rst && (!requests.valid || offer_taken)) begin
      if (pending.size() > 0 && pending[0].drain && display_q.size() == 0)
        void'(pending.pop_front());
      if (pending.size() > 0 && !pending[0].drain &&
          (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_req = pending.pop_front();
        requests.valid        <= 1'b1;
        requests.action       <= cur_req.action;
        requests.button_level <= cur_req.button_level;
        requests.mode_number  <= cur_req.mode_number;
        requests.new_period   <= cur_req.new_period;
        requests.new_length   <= cur_req.new_length;
        requests.new_colors   <= cur_req.new_colors;
      end else begin
        requests.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    offer_taken <= !rst && requests.valid && requests.ready;
    if (!rst && requests.valid && requests.ready) begin
      play_request(cur_req);
      reqs_taken <= reqs_taken + 1;
    end
  end

  // result side, with one long hold-off
  always @(negedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      results.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst && results.valid && results.ready) begin
      results_seen <= results_seen + 1;
      if (display_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result color %0d mode %0d",
                                  results.led_color, results.active_mode));
      end else begin
        want = display_q.pop_front();
        if (results.led_color !== want.led_color)
          report_mismatch($sformatf("led_color %0d, expected %0d",
                                    results.led_color, want.led_color));
        if (results.active_mode !== want.active_mode)
          report_mismatch($sformatf("active_mode %0d, expected %0d",
                                    results.active_mode, want.active_mode));
        if (results.echo_period !== want.echo_period)
          report_mismatch($sformatf("echo_period %0d, expected %0d",
                                    results.echo_period, want.echo_period));
        if (results.echo_length !== want.echo_length)
          report_mismatch($sformatf("echo_length %0d, expected %0d",
                                    results.echo_length, want.echo_length));
        if (results.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    results.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (requests.valid && requests.ready) || (results.valid && results.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("led_pattern_sequencer test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    request_t r;
    int n;
    int pick;
    int burst;
    bit drained;
    clk = 1'b0;
    rst = 1'b1;
    requests.valid        = 1'b0;
    requests.action       = '0;
    requests.button_level = 1'b0;
    requests.mode_number  = '0;
    requests.new_period   = '0;
    requests.new_length   = '0;
    requests.new_colors   = '0;
    results.ready         = 1'b0;

    for (int i = 0; i < SLOTS; i++) begin
      pat_period[i] = '0;
      pat_len[i]    = '0;
      pat_colors[i] = '0;
      pat_step[i]   = '0;
      pat_sub[i]    = '0;
    end
    pat_period[0] = 16'd500;  pat_len[0] = 4'd4; pat_colors[0] = 16'h00D9;
    pat_period[1] = 16'd200;  pat_len[1] = 4'd3; pat_colors[1] = 16'h002D;
    pat_period[2] = 16'd5000; pat_len[2] = 4'd2; pat_colors[2] = 16'h0009;
    pat_period[3] = 16'd75;   pat_len[3] = 4'd6; pat_colors[3] = 16'h09B7;
    play_mode     = '0;
    defined_modes = COUNT_BITS'(BUILTIN_SLOTS);
    ring_slot     = SLOT_BITS'(BUILTIN_SLOTS);
    btn_held      = 1'b0;

    // directed: button edges, mode limits, rejects, ring wrap, step wrap
    pending.push_back(make_request(ACT_TICK, 1'b1, 4'd15, 16'hFFFF, 4'd15, 16'hFFFF));
    pending.push_back(make_request(ACT_BUTTON, 1'b1, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_BUTTON, 1'b1, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_BUTTON, 1'b0, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_BUTTON, 1'b1, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd15, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd5, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd4, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'h0, 4'd8, 16'hFFFF));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd10, 4'd0, 16'hFFFF));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd10, 4'd9, 16'hFFFF));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'hFFFF, 4'd15, 16'hFFFF));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'hFFFF, 4'd8, 16'hFFFF));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd1, 4'd8, 16'hE4E4));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd2, 4'd1, 16'h0003));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd1, 4'd3, 16'h0039));
    pending.push_back(make_request(ACT_NEW_PATTERN, 1'b0, 4'd0, 16'd3, 4'd2, 16'h000E));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd8, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_SET_MODE, 1'b0, 4'd9, 16'h0, 4'd0, 16'h0));
    repeat (3) pending.push_back(make_request(ACT_TICK, 1'b0, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_BUTTON, 1'b0, 4'd0, 16'h0, 4'd0, 16'h0));
    pending.push_back(make_request(ACT_BUTTON, 1'b1, 4'd0, 16'h0, 4'd0, 16'h0));

    n = 0;
    drained = 1'b0;
    while (n < RANDOM_ITEMS) begin
      if (!drained && n >= DRAIN_AT) begin
        r = '0;
        r.drain = 1'b1;
        pending.push_back(r);
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      burst = 1;
      r = make_request(ACT_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       16'($urandom), 4'($urandom_range(0, 15)), 16'($urandom));
      if (pick < 10) begin
        burst = $urandom_range(5, 60);
      end else if (pick >= 45) begin
        if (pick < 60) begin
          r.action = ACT_BUTTON;
        end else if (pick < 72) begin
          r.action = ACT_SET_MODE;
          if ($urandom_range(0, 4) != 0) r.mode_number = 4'($urandom_range(1, SLOTS));
        end else if (pick < 88) begin
          r.action = ACT_NEW_PATTERN;
          if ($urandom_range(0, 9) != 0) r.new_period = 16'($urandom_range(1, 6));
          r.new_length = 4'($urandom_range(1, MAX_STEPS));
        end else begin
          r.action = ACT_NEW_PATTERN;
          case ($urandom_range(0, 2))
            0: r.new_period = '0;
            1: r.new_length = '0;
            default: r.new_length = 4'($urandom_range(MAX_STEPS + 1, 15));
          endcase
        end
      end
      repeat (burst) begin
        pending.push_back(r);
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (!(pending.size() == 0 && !requests.valid && display_q.size() == 0))
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("led_pattern_sequencer test passed");
    else
      $display("led_pattern_sequencer test failed");
    $finish;
  end

endmodule
